### design/wstd_pkg.sv
// Shared types and constants for the text frame deframer.
// No dependencies; every other design file imports this package.
`default_nettype none

package wstd_pkg;

    // One incoming beat: a raw frame byte and the end-of-frame marker.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_beat;

    // One outgoing beat: payload byte and end-of-frame status.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_done;
        logic [1:0] frame_status;
    } t_out_beat;

    // Frame status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_NOTEXT = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    // Header field values
    localparam logic [3:0] OPCODE_TEXT = 4'h1;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

`default_nettype wire

### design/wstd_in_stage.sv
// Input register stage: holds one received beat until the parser takes it.
// Depends on wstd_pkg for the input beat type.
`default_nettype none

module wstd_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wstd_pkg::t_in_beat   i_beat,
    output logic                 o_stall,
    input  wire                  i_take,
    output logic                 o_valid,
    output wstd_pkg::t_in_beat   o_beat
);
    import wstd_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;
    logic     accept;

    // Holding a beat the parser cannot take this cycle blocks the upstream side
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

### design/wstd_parse.sv
// Header parser and payload counter: one byte per cycle unless output is full; state updated on take.
// Depends on wstd_pkg for beat types, status codes and header constants.
`default_nettype none

module wstd_parse (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wstd_pkg::t_in_beat   i_beat,
    input  wire                  i_out_free,
    output logic                 o_take,
    output logic                 o_res_valid,
    output wstd_pkg::t_out_beat  o_res
);
    import wstd_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DROP    = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic [3:0]  r_ext,    n_ext;
    logic [63:0] r_accum,  n_accum;
    logic [63:0] r_left,   n_left;
    logic [1:0]  r_sticky, n_sticky;

    logic [7:0]  b;
    logic        last;
    logic [6:0]  len7;
    logic [63:0] accum_sh;
    logic [3:0]  ext_dec;
    logic [63:0] left_dec;
    logic        left_last;
    logic        pay_valid;
    logic [1:0]  status;
    logic        has_res;

    assign b         = i_beat.frame_byte;
    assign last      = i_beat.frame_end;
    assign len7      = b[6:0];
    assign accum_sh  = {r_accum[55:0], b};
    assign ext_dec   = r_ext - 4'd1;
    assign left_dec  = r_left - 64'd1;
    // last payload byte: compare the count directly rather than after the decrement
    assign left_last = (r_left == 64'd1);

    always_comb begin
        n_phase   = r_phase;
        n_ext     = r_ext;
        n_accum   = r_accum;
        n_left    = r_left;
        n_sticky  = r_sticky;
        pay_valid = 1'b0;
        status    = ST_OK;

        case (r_phase)
            PH_HDR0: begin
                if (b[3:0] != OPCODE_TEXT) begin
                    n_sticky = ST_NOTEXT;
                    n_phase  = PH_DROP;
                end else begin
                    n_phase = PH_HDR1;
                end
                if (last) begin
                    status = ST_SHORT;
                end
            end
            PH_HDR1: begin
                if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                    n_ext   = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_accum = 64'd0;
                    n_phase = PH_EXT;
                    if (last) begin
                        status = ST_SHORT;
                    end
                end else begin
                    n_left   = {57'd0, len7};
                    n_sticky = ST_OK;
                    n_phase  = (len7 == 7'd0) ? PH_DROP : PH_PAYLOAD;
                    if (last) begin
                        status = (len7 == 7'd0) ? ST_OK : ST_TRUNC;
                    end
                end
            end
            PH_EXT: begin
                n_accum = accum_sh;
                n_ext   = ext_dec;
                if (ext_dec == 4'd0) begin
                    n_left   = accum_sh;
                    n_sticky = ST_OK;
                    n_phase  = (accum_sh == 64'd0) ? PH_DROP : PH_PAYLOAD;
                    if (last) begin
                        status = (accum_sh == 64'd0) ? ST_OK : ST_TRUNC;
                    end
                end else if (last) begin
                    status = ST_SHORT;
                end
            end
            PH_PAYLOAD: begin
                pay_valid = 1'b1;
                n_left    = left_dec;
                if (left_last) begin
                    n_phase  = PH_DROP;
                    n_sticky = ST_OK;
                end
                if (last) begin
                    status = left_last ? ST_OK : ST_TRUNC;
                end
            end
            default: begin
                // dropping, and the unused codes behave the same
                if (last) begin
                    status = r_sticky;
                end
            end
        endcase

        // frame end puts every piece of state back to its reset value
        if (last) begin
            n_phase  = PH_HDR0;
            n_ext    = 4'd0;
            n_accum  = 64'd0;
            n_left   = 64'd0;
            n_sticky = ST_OK;
        end
    end

    // Beats that give no result need no room downstream
    assign has_res     = (r_phase == PH_PAYLOAD) || last;
    assign o_take      = i_valid && (!has_res || i_out_free);
    assign o_res_valid = o_take && has_res;

    always_comb begin
        o_res.payload_byte = pay_valid ? b : 8'd0;
        o_res.byte_valid   = pay_valid;
        o_res.frame_done   = last;
        o_res.frame_status = last ? status : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_ext    <= 4'd0;
            r_accum  <= 64'd0;
            r_left   <= 64'd0;
            r_sticky <= ST_OK;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_ext    <= n_ext;
            r_accum  <= n_accum;
            r_left   <= n_left;
            r_sticky <= n_sticky;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && last) |=> (r_phase == PH_HDR0 && r_left == 64'd0 && r_ext == 4'd0))
        else $error("state not cleared after frame end");

    a_payload_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != 64'd0))
        else $error("payload phase with nothing left to count");

    a_ext_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXT) |-> (r_ext != 4'd0 && r_ext <= EXT64_BYTES))
        else $error("extended length count out of range");

endmodule

`default_nettype wire

### design/wstd_out_stage.sv
// Result register: holds one output beat until the receiver takes it.
// Depends on wstd_pkg for the output beat type.
`default_nettype none

module wstd_out_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  wstd_pkg::t_out_beat  i_beat,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire                  i_stall,
    output wstd_pkg::t_out_beat  o_beat
);
    import wstd_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    // Room for a new beat when empty or when the held one leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

### design/websocket_text_frame_deframer_top.sv
// Top level of the text frame deframer: input stage, parser, result register.
// Depends on wstd_pkg, wstd_in_stage, wstd_parse and wstd_out_stage.
//
// Usage: frame bytes enter on the input channel (i_in_valid / o_in_stall),
// one byte per beat, with frame_end set on the last byte of each frame.
// Payload bytes and the end-of-frame status leave on the output channel
// (o_out_valid / i_out_stall). Header and dropped bytes give no output
// beat unless they end a frame; a final byte gives frame_done with status
// ok, header short, not text or payload truncated.
// Path: an accepted byte is registered in the input stage, parsed
// combinationally, then held in the result register until taken.
// Throughput: one byte per cycle unless stalled; the parse state (the
// 64-bit payload countdown and length shift register) updates per byte.
// Reset: synchronous, active low; the parser returns to awaiting the
// first header byte and both stages empty. No clearing pass is needed.
// Stall: a stalled result holds in the output register; the parser
// still takes bytes that give no output, and the input register holds one
// more beat before o_in_stall rises.
`default_nettype none

module websocket_text_frame_deframer_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wstd_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wstd_pkg::t_out_beat  o_out_beat
);
    import wstd_pkg::*;

    logic      s1_valid;
    t_in_beat  s1_beat;
    logic      take;
    logic      res_valid;
    t_out_beat res;
    logic      out_free;

    wstd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_beat  (s1_beat)
    );

    wstd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_beat      (s1_beat),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wstd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_beat  (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

    a_beat_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.byte_valid || o_out_beat.frame_done))
        else $error("output beat carries neither payload nor status");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.frame_done) |-> (o_out_beat.frame_status == ST_OK))
        else $error("status set on a beat that does not end a frame");

    a_byte_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.byte_valid) |-> (o_out_beat.payload_byte == 8'd0))
        else $error("payload byte not zero on a status-only beat");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !res_valid)
        else $error("result loaded over a stalled output beat");

endmodule

`default_nettype wire
